// File: rtl/pscm_pkg.sv
// ----------------------------------------------------------------------------
// pscm_pkg
// Shared types and constants of the pair sum match counter.
// ----------------------------------------------------------------------------
package pscm_pkg;

  localparam int TABLE_SIZE_DEF  = 1024;
  localparam int COUNT_WIDTH_DEF = 16;

  localparam int VALUE_W = 32;
  localparam int COMP_W  = 33;
  localparam int PAIR_W  = 16;

  // result of one item, handed from the engine to the output register
  typedef struct packed {
    logic [COMP_W-1:0]  complement;
    logic [VALUE_W-1:0] value_echo;
    logic [PAIR_W-1:0]  pair_count;
    logic               table_full;
  } result_t;

endpackage

// File: rtl/pscm_ram.sv
// ----------------------------------------------------------------------------
// pscm_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module pscm_ram #(
  parameter int AW = 10,
  parameter int DW = 48
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/pscm_engine.sv
// ----------------------------------------------------------------------------
// pscm_engine
// Scans the occupied table entries, then bumps the value's own entry or appends a new one.
// ----------------------------------------------------------------------------
module pscm_engine #(
  parameter int TABLE_SIZE  = pscm_pkg::TABLE_SIZE_DEF,
  parameter int COUNT_WIDTH = pscm_pkg::COUNT_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [pscm_pkg::VALUE_W-1:0]        in_value,
  input  logic                                in_start,
  input  logic [pscm_pkg::VALUE_W-1:0]        target_sum,
  input  logic                                out_free,
  output logic                                res_valid,
  output pscm_pkg::result_t                   res
);

  localparam int AW = $clog2(TABLE_SIZE);
  localparam int UW = AW + 1;
  localparam int DW = pscm_pkg::VALUE_W + COUNT_WIDTH;
  localparam int PW = pscm_pkg::PAIR_W;
  localparam logic [UW-1:0] SIZE_U = UW'(TABLE_SIZE);
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
  localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_WRITE = 2'd2;

  logic [1:0]                      state;
  logic [UW-1:0]                   used;
  logic [UW-1:0]                   idx;
  logic                            rd_pend;
  logic [AW-1:0]                   rd_addr_q;
  logic [pscm_pkg::VALUE_W-1:0]    val;
  logic [pscm_pkg::COMP_W-1:0]     comp;
  logic                            comp_ok;
  logic                            comp_hit;
  logic [COUNT_WIDTH-1:0]          comp_cnt;
  logic                            self_hit;
  logic [COUNT_WIDTH-1:0]          self_cnt;
  logic [AW-1:0]                   self_slot;

  logic                            accept;
  logic                            issue;
  logic [DW-1:0]                   rd_data;
  logic [pscm_pkg::VALUE_W-1:0]    rd_key;
  logic [COUNT_WIDTH-1:0]          rd_cnt;
  logic                            wr_en;
  logic [AW-1:0]                   wr_addr;
  logic [DW-1:0]                   wr_data;
  logic [pscm_pkg::COMP_W-1:0]     comp_in;
  logic [COUNT_WIDTH+PW-1:0]       pair_ext;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign issue    = (state == ST_SCAN) && (idx < used);
  assign rd_key   = rd_data[DW-1 -: pscm_pkg::VALUE_W];
  assign rd_cnt   = rd_data[COUNT_WIDTH-1:0];
  assign comp_in  = {target_sum[pscm_pkg::VALUE_W-1], target_sum}
                  - {in_value[pscm_pkg::VALUE_W-1], in_value};

  pscm_ram #(.AW(AW), .DW(DW)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (issue),
    .rd_addr (idx[AW-1:0]),
    .rd_data (rd_data)
  );

  // write back: bump the found entry, else append a new one while room is left
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = used[AW-1:0];
    wr_data = {val, CNT_ONE};
    if (state == ST_WRITE && out_free) begin
      if (self_hit) begin
        wr_en   = 1'b1;
        wr_addr = self_slot;
        wr_data = {val, (self_cnt == CNT_MAX) ? self_cnt : self_cnt + CNT_ONE};
      end else if (used < SIZE_U) begin
        wr_en = 1'b1;
      end
    end
  end

  // clamp the complement's count into the pair field
  assign pair_ext = {{PW{1'b0}}, (comp_hit ? comp_cnt : {COUNT_WIDTH{1'b0}})};

  always_comb begin
    res_valid       = (state == ST_WRITE) && out_free;
    res.complement  = comp;
    res.value_echo  = val;
    res.pair_count  = (|pair_ext[COUNT_WIDTH+PW-1:PW]) ? {PW{1'b1}} : pair_ext[PW-1:0];
    res.table_full  = !self_hit && !(used < SIZE_U);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      used    <= '0;
      idx     <= '0;
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= issue;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (in_start) begin
              used <= '0;
            end
            idx   <= '0;
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (issue) begin
            idx <= idx + UW'(1);
          end else if (!rd_pend) begin
            state <= ST_WRITE;
          end
        end
        ST_WRITE: begin
          if (out_free) begin
            if (!self_hit && used < SIZE_U) begin
              used <= used + UW'(1);
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      val      <= in_value;
      comp     <= comp_in;
      comp_ok  <= (comp_in[pscm_pkg::COMP_W-1] == comp_in[pscm_pkg::COMP_W-2]);
      comp_hit <= 1'b0;
      self_hit <= 1'b0;
    end else if (rd_pend) begin
      if (comp_ok && rd_key == comp[pscm_pkg::VALUE_W-1:0]) begin
        comp_hit <= 1'b1;
        comp_cnt <= rd_cnt;
      end
      if (rd_key == val) begin
        self_hit  <= 1'b1;
        self_cnt  <= rd_cnt;
        self_slot <= rd_addr_q;
      end
    end
    if (issue) begin
      rd_addr_q <= idx[AW-1:0];
    end
  end

  a_used_bound: assert property (@(posedge clk) disable iff (rst) used <= SIZE_U)
    else $error("fill count beyond table size");
  a_read_in_scan: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> $past(state) == ST_SCAN)
    else $error("read data outside a scan");
  a_res_leaves_write: assert property (@(posedge clk) disable iff (rst)
    res_valid |=> state == ST_IDLE)
    else $error("engine stayed busy after its result");
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> idx <= used)
    else $error("scan index beyond fill count");

endmodule

// File: rtl/pair_sum_match_counter.sv
// ----------------------------------------------------------------------------
// pair_sum_match_counter
// Streaming two-sum pair counter over a table of distinct values.
// ----------------------------------------------------------------------------
// Flow: an input beat is accepted only while the engine is idle; it then scans
//   the stored distinct values, one entry per cycle through the single table
//   RAM read port, writes back and hands its result to the output register;
//   a held result beat stalls the engine. The next beat waits for that handover.
// Reset: rst clears the fill count (table empty), target_sum to 0 and all
//   handshake state; no clearing pass over the RAM is needed.
module pair_sum_match_counter #(
  parameter int TABLE_SIZE  = pscm_pkg::TABLE_SIZE_DEF,
  parameter int COUNT_WIDTH = pscm_pkg::COUNT_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] value
  input  logic        s_tuser,   // [0] start_req
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [87:0] m_tdata,   // [32:0] complement, [64:33] value_echo,
                                 // [80:65] pair_count, [87:81] zero
  output logic        m_tuser,   // [0] table_full
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [31:0]       target_sum;
  logic              out_free;
  logic              res_valid;
  pscm_pkg::result_t res;
  pscm_pkg::result_t out_q;

  // single register at word 0; the low byte-address bits are not decoded
  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : target_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_sum <= '0;
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      target_sum <= pwdata;
    end
  end

  // the engine hands over a result only when the output register can take it
  assign out_free = !m_tvalid || m_tready;

  pscm_engine #(.TABLE_SIZE(TABLE_SIZE), .COUNT_WIDTH(COUNT_WIDTH)) u_engine (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_value   (s_tdata),
    .in_start   (s_tuser),
    .target_sum (target_sum),
    .out_free   (out_free),
    .res_valid  (res_valid),
    .res        (res)
  );

  // output register: hold the beat until taken, load the next one on handover
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign m_tdata = {7'd0, out_q.pair_count, out_q.value_echo, out_q.complement};
  assign m_tuser = out_q.table_full;

endmodule
